### rtl/core/frua_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame ring upload allocator package
// Shared widths, opcode encoding and the structs passed between the core
// modules.
// ----------------------------------------------------------------------------
package frua_pkg;

   localparam int FRAME_COUNT_DEF = 3;

   localparam int OP_W    = 3;
   localparam int SLOT_W  = 3;
   localparam int FENCE_W = 64;
   localparam int CAP_W   = 32;
   localparam int SIZE_W  = 32;
   localparam int ALIGN_W = 17;

   // Aligned offset needs one carry bit above the 32-bit offset.
   localparam int SUM_W = CAP_W + 1;

   typedef enum logic [OP_W-1:0] {
      OP_BEGIN         = 3'd0,
      OP_ADVANCE       = 3'd1,
      OP_SET_FENCE     = 3'd2,
      OP_GET_FENCE     = 3'd3,
      OP_ALLOC         = 3'd4,
      OP_RESET_OFFSET  = 3'd5,
      OP_SET_CUR_FENCE = 3'd6,
      OP_CLEAR         = 3'd7
   } op_type;

   typedef struct packed {
      logic               clear;
      logic               slot_we;
      logic [SLOT_W-1:0]  slot_next;
      logic               fence_we;
      logic [SLOT_W-1:0]  fence_idx;
      logic [FENCE_W-1:0] fence_data;
      logic               off_we;
      logic [SLOT_W-1:0]  off_idx;
      logic [CAP_W-1:0]   off_data;
   } ring_upd_type;

   typedef struct packed {
      logic               ok;
      logic [CAP_W-1:0]   alloc_offset;
      logic [FENCE_W-1:0] fence_out;
      logic [SLOT_W-1:0]  current_slot;
   } rsp_type;

endpackage

### rtl/core/frua_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame ring upload allocator channels
// Request, response and capacity write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface frua_req_if;
   logic                         valid;
   logic                         ready;
   logic [frua_pkg::OP_W-1:0]    opcode;
   logic [frua_pkg::SLOT_W-1:0]  slot_index;
   logic [frua_pkg::FENCE_W-1:0] fence_value;
   logic [frua_pkg::SIZE_W-1:0]  size_bytes;
   logic [frua_pkg::ALIGN_W-1:0] alignment;

   modport source (output valid, opcode, slot_index, fence_value, size_bytes, alignment,
                   input ready);
   modport sink (input valid, opcode, slot_index, fence_value, size_bytes, alignment,
                 output ready);
endinterface

interface frua_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         ok;
   logic [frua_pkg::CAP_W-1:0]   alloc_offset;
   logic [frua_pkg::FENCE_W-1:0] fence_out;
   logic [frua_pkg::SLOT_W-1:0]  current_slot;

   modport source (output valid, ok, alloc_offset, fence_out, current_slot, input ready);
   modport sink (input valid, ok, alloc_offset, fence_out, current_slot, output ready);
endinterface

interface frua_csr_if;
   logic                       valid;
   logic                       ready;
   logic [frua_pkg::CAP_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

### rtl/core/frua_ring_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame ring state
// Current slot pointer plus per-slot fence and upload offset registers.
// ----------------------------------------------------------------------------
module frua_ring_state #(
   parameter int FRAME_COUNT = frua_pkg::FRAME_COUNT_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  frua_pkg::ring_upd_type       upd,
   input  logic [frua_pkg::SLOT_W-1:0]  fence_raddr,
   output logic [frua_pkg::SLOT_W-1:0]  cur_slot,
   output logic [frua_pkg::FENCE_W-1:0] fence_rdata,
   output logic [frua_pkg::CAP_W-1:0]   off_rdata
);

   localparam int IDX_W = $clog2(FRAME_COUNT);
   localparam logic [frua_pkg::SLOT_W:0] COUNT_EXT = (frua_pkg::SLOT_W + 1)'(FRAME_COUNT);

   logic [IDX_W-1:0]             slot_ff;
   logic [IDX_W-1:0]             slot_in;
   logic [frua_pkg::FENCE_W-1:0] fence_ff [FRAME_COUNT];
   logic [frua_pkg::FENCE_W-1:0] fence_in [FRAME_COUNT];
   logic [frua_pkg::CAP_W-1:0]   off_ff [FRAME_COUNT];
   logic [frua_pkg::CAP_W-1:0]   off_in [FRAME_COUNT];

   always_comb begin
      slot_in  = slot_ff;
      fence_in = fence_ff;
      off_in   = off_ff;
      if (upd.clear) begin
         slot_in = '0;
         for (int i = 0; i < FRAME_COUNT; i++) begin
            fence_in[i] = '0;
            off_in[i]   = '0;
         end
      end else begin
         if (upd.slot_we) begin
            slot_in = upd.slot_next[IDX_W-1:0];
         end
         if (upd.fence_we) begin
            fence_in[upd.fence_idx[IDX_W-1:0]] = upd.fence_data;
         end
         if (upd.off_we) begin
            off_in[upd.off_idx[IDX_W-1:0]] = upd.off_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         for (int i = 0; i < FRAME_COUNT; i++) begin
            fence_ff[i] <= '0;
            off_ff[i]   <= '0;
         end
      end else begin
         slot_ff  <= slot_in;
         fence_ff <= fence_in;
         off_ff   <= off_in;
      end
   end

   assign cur_slot    = frua_pkg::SLOT_W'(slot_ff);
   assign fence_rdata = ({1'b0, fence_raddr} < COUNT_EXT) ?
                        fence_ff[fence_raddr[IDX_W-1:0]] : '0;
   assign off_rdata   = off_ff[slot_ff];

   a_clear_to_slot_zero: assert property (@(posedge clock) disable iff (reset)
      upd.clear |=> slot_ff == '0)
      else $error("ring clear did not return to slot zero");

   a_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cur_slot} < COUNT_EXT)
      else $error("current slot beyond ring size");

   a_no_write_past_ring: assert property (@(posedge clock) disable iff (reset)
      (upd.fence_we || upd.off_we) && !upd.clear |->
         ({1'b0, upd.fence_idx} < COUNT_EXT || !upd.fence_we) &&
         ({1'b0, upd.off_idx} < COUNT_EXT || !upd.off_we))
      else $error("slot write index beyond ring size");

endmodule

### rtl/core/frua_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame ring operation execute
// Decodes one request word against the ring state and forms both the ring
// update and the response word.
// ----------------------------------------------------------------------------
module frua_exec #(
   parameter int FRAME_COUNT = frua_pkg::FRAME_COUNT_DEF
) (
   input  logic [frua_pkg::OP_W-1:0]    opcode,
   input  logic [frua_pkg::SLOT_W-1:0]  slot_index,
   input  logic [frua_pkg::FENCE_W-1:0] fence_value,
   input  logic [frua_pkg::SIZE_W-1:0]  size_bytes,
   input  logic [frua_pkg::ALIGN_W-1:0] alignment,
   input  logic [frua_pkg::CAP_W-1:0]   capacity,
   input  logic [frua_pkg::SLOT_W-1:0]  cur_slot,
   input  logic [frua_pkg::FENCE_W-1:0] fence_rdata,
   input  logic [frua_pkg::CAP_W-1:0]   off_rdata,
   output logic [frua_pkg::SLOT_W-1:0]  fence_raddr,
   output frua_pkg::ring_upd_type       upd,
   output frua_pkg::rsp_type            rsp
);

   localparam logic [frua_pkg::SLOT_W:0] COUNT_EXT = (frua_pkg::SLOT_W + 1)'(FRAME_COUNT);
   localparam logic [frua_pkg::SLOT_W-1:0] LAST_SLOT = frua_pkg::SLOT_W'(FRAME_COUNT - 1);
   localparam int PAD_W = frua_pkg::SUM_W - frua_pkg::ALIGN_W;

   frua_pkg::op_type               op;
   logic [frua_pkg::SLOT_W-1:0]    next_slot;
   logic                           idx_in_range;
   logic [frua_pkg::ALIGN_W-1:0]   align_m1;
   logic [frua_pkg::SUM_W-1:0]     bumped;
   logic [frua_pkg::SUM_W-1:0]     aligned;
   logic [frua_pkg::SUM_W-1:0]     cap_ext;
   logic                           fits;
   logic [frua_pkg::CAP_W-1:0]     new_off;

   assign op           = frua_pkg::op_type'(opcode);
   assign next_slot    = (cur_slot == LAST_SLOT) ? '0 : cur_slot + 1'b1;
   assign idx_in_range = {1'b0, slot_index} < COUNT_EXT;
   assign fence_raddr  = (op == frua_pkg::OP_BEGIN) ? next_slot : slot_index;

   // Round up at 33 bits; the mask's upper bits stay set.
   assign align_m1 = alignment - 1'b1;
   assign bumped   = {1'b0, off_rdata} + frua_pkg::SUM_W'(align_m1);
   assign aligned  = (alignment > frua_pkg::ALIGN_W'(1)) ?
                     (bumped & {{PAD_W{1'b1}}, ~align_m1}) : {1'b0, off_rdata};
   assign cap_ext  = {1'b0, capacity};
   assign fits     = (aligned <= cap_ext) &&
                     ({1'b0, size_bytes} <= (cap_ext - aligned));
   assign new_off  = aligned[frua_pkg::CAP_W-1:0] + size_bytes;

   always_comb begin
      upd              = '0;
      rsp.ok           = 1'b1;
      rsp.alloc_offset = '0;
      rsp.fence_out    = '0;
      rsp.current_slot = cur_slot;
      case (op)
         frua_pkg::OP_BEGIN: begin
            if (fence_rdata > fence_value) begin
               rsp.ok = 1'b0;
            end else begin
               upd.slot_we      = 1'b1;
               upd.slot_next    = next_slot;
               upd.off_we       = 1'b1;
               upd.off_idx      = next_slot;
               rsp.current_slot = next_slot;
            end
         end
         frua_pkg::OP_ADVANCE: begin
            upd.slot_we      = 1'b1;
            upd.slot_next    = next_slot;
            upd.off_we       = 1'b1;
            upd.off_idx      = next_slot;
            rsp.current_slot = next_slot;
         end
         frua_pkg::OP_SET_FENCE: begin
            // Drop writes to slots beyond the ring.
            upd.fence_we   = idx_in_range;
            upd.fence_idx  = slot_index;
            upd.fence_data = fence_value;
         end
         frua_pkg::OP_GET_FENCE: begin
            if (idx_in_range) begin
               rsp.fence_out = fence_rdata;
            end
         end
         frua_pkg::OP_ALLOC: begin
            if (fits) begin
               rsp.alloc_offset = aligned[frua_pkg::CAP_W-1:0];
               upd.off_we       = 1'b1;
               upd.off_idx      = cur_slot;
               upd.off_data     = new_off;
            end else begin
               rsp.ok = 1'b0;
            end
         end
         frua_pkg::OP_RESET_OFFSET: begin
            upd.off_we  = 1'b1;
            upd.off_idx = cur_slot;
         end
         frua_pkg::OP_SET_CUR_FENCE: begin
            upd.fence_we   = 1'b1;
            upd.fence_idx  = cur_slot;
            upd.fence_data = fence_value;
         end
         frua_pkg::OP_CLEAR: begin
            upd.clear        = 1'b1;
            rsp.current_slot = '0;
         end
         default: begin
            upd.clear        = 1'b1;
            rsp.current_slot = '0;
         end
      endcase
   end

endmodule

### rtl/core/frame_ring_upload_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame ring upload allocator
// Ring of frame slots with fences and bump-pointer upload offsets.
// ----------------------------------------------------------------------------
// One request word is accepted per clock unless the block stalls, and one
// response word is produced for each. A request is captured in an input
// register, executed against the ring state, and its response lands in an
// output register. Throughput is one word per cycle while responses are
// taken; the execute step reads and updates the ring's fence and offset
// registers. The input register keeps taking words while a response waits,
// and stalls only when both registers are full and the response is not taken.
// The capacity register may be written at any cycle while the block is idle.
// ----------------------------------------------------------------------------
module frame_ring_upload_allocator_top #(
   parameter int FRAME_COUNT = frua_pkg::FRAME_COUNT_DEF
) (
   input  logic  clock,
   input  logic  reset,
   frua_req_if.sink   req,
   frua_rsp_if.source rsp,
   frua_csr_if.sink   csr
);

   localparam logic [frua_pkg::SLOT_W:0] COUNT_EXT = (frua_pkg::SLOT_W + 1)'(FRAME_COUNT);

   logic                         in_valid_ff, in_valid_in;
   logic [frua_pkg::OP_W-1:0]    op_ff;
   logic [frua_pkg::SLOT_W-1:0]  idx_ff;
   logic [frua_pkg::FENCE_W-1:0] fence_ff;
   logic [frua_pkg::SIZE_W-1:0]  size_ff;
   logic [frua_pkg::ALIGN_W-1:0] align_ff;
   logic [frua_pkg::CAP_W-1:0]   cap_ff, cap_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   frua_pkg::rsp_type            rsp_ff, rsp_in;

   logic                         take_req;
   logic                         execute;
   frua_pkg::ring_upd_type       upd_raw, upd;
   logic [frua_pkg::SLOT_W-1:0]  cur_slot;
   logic [frua_pkg::SLOT_W-1:0]  fence_raddr;
   logic [frua_pkg::FENCE_W-1:0] fence_rdata;
   logic [frua_pkg::CAP_W-1:0]   off_rdata;

   assign execute   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || !rsp_valid_ff || rsp.ready;
   assign take_req  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   // Hold ring state unless the word in the input register executes.
   assign upd = execute ? upd_raw : '0;

   frua_exec #(
      .FRAME_COUNT (FRAME_COUNT)
   ) u_exec (
      .opcode      (op_ff),
      .slot_index  (idx_ff),
      .fence_value (fence_ff),
      .size_bytes  (size_ff),
      .alignment   (align_ff),
      .capacity    (cap_ff),
      .cur_slot    (cur_slot),
      .fence_rdata (fence_rdata),
      .off_rdata   (off_rdata),
      .fence_raddr (fence_raddr),
      .upd         (upd_raw),
      .rsp         (rsp_in)
   );

   frua_ring_state #(
      .FRAME_COUNT (FRAME_COUNT)
   ) u_ring_state (
      .clock       (clock),
      .reset       (reset),
      .upd         (upd),
      .fence_raddr (fence_raddr),
      .cur_slot    (cur_slot),
      .fence_rdata (fence_rdata),
      .off_rdata   (off_rdata)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (take_req) begin
         in_valid_in = 1'b1;
      end else if (execute) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      cap_in = csr.valid ? csr.data : cap_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         op_ff    <= req.opcode;
         idx_ff   <= req.slot_index;
         fence_ff <= req.fence_value;
         size_ff  <= req.size_bytes;
         align_ff <= req.alignment;
      end
      if (execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.ok           = rsp_ff.ok;
   assign rsp.alloc_offset = rsp_ff.alloc_offset;
   assign rsp.fence_out    = rsp_ff.fence_out;
   assign rsp.current_slot = rsp_ff.current_slot;

   a_execute_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      execute |=> rsp_valid_ff)
      else $error("executed word produced no response");

   a_stalled_word_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !execute |=> in_valid_ff)
      else $error("stalled request word lost");

   a_rsp_slot_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> {1'b0, rsp_ff.current_slot} < COUNT_EXT)
      else $error("response slot beyond ring size");

   a_alloc_within_cap: assert property (@(posedge clock) disable iff (reset)
      execute && upd_raw.off_we |-> upd_raw.off_data <= cap_ff)
      else $error("slot offset written beyond upload capacity");

endmodule
